[src/wifi_frame_airtime_core_defines.svh]
// Assertion macros for the frame air time core.
`ifndef WIFI_FRAME_AIRTIME_CORE_DEFINES_SVH
`define WIFI_FRAME_AIRTIME_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define WFA_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("wfa check failed");
`define WFA_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("wfa check failed");
`else
`define WFA_ASSERT_NOW(label, pre, post)
`define WFA_ASSERT_NEXT(label, pre, post)
`endif
`endif

[src/wfa_pkg.sv]
// Types, codes and HT MCS tables shared by the frame air time core.
package wfa_pkg;

  localparam int unsigned NumW = 21;
  localparam int unsigned DenW = 13;
  localparam int unsigned DurW = 21;
  localparam logic [6:0] McsTop = 7'd76;

  localparam logic [2:0] PhyDsss = 3'd1;
  localparam logic [2:0] PhyOfdm = 3'd2;
  localparam logic [2:0] PhyHt   = 3'd3;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StUnsupp  = 2'd1;
  localparam logic [1:0] StStreams = 2'd2;
  localparam logic [1:0] StMcs     = 2'd3;

  typedef enum logic [1:0] {
    MODE_DSSS,
    MODE_OFDM,
    MODE_HT,
    MODE_ERR
  } mode_e;

  // Sideband that rides along with every divider beat.
  typedef struct packed {
    mode_e      mode;
    logic [1:0] status;
    logic [7:0] base;
    logic       stbc2;
    logic       sgi;
  } side_t;

  localparam logic [2:0] McsStreams [77] = '{
    3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,
    3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,
    3'd1,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,
    3'd3,3'd3,3'd3,3'd3,3'd3,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,
    3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4
  };

  localparam logic [1:0] McsEncoders [77] = '{
    2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,
    2'd1,2'd1,2'd1,2'd1,2'd1,2'd2,2'd2,2'd2,2'd1,2'd1,2'd1,2'd1,2'd2,2'd2,2'd2,2'd2,
    2'd1,
    2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,
    2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,
    2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,
    2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2
  };

  localparam logic [9:0] McsBitsPerSym [77] = '{
    10'd26, 10'd52, 10'd78, 10'd104, 10'd156, 10'd208, 10'd234, 10'd260,
    10'd52, 10'd104, 10'd156, 10'd208, 10'd312, 10'd416, 10'd468, 10'd520,
    10'd78, 10'd156, 10'd234, 10'd312, 10'd468, 10'd624, 10'd702, 10'd780,
    10'd104, 10'd208, 10'd312, 10'd416, 10'd624, 10'd832, 10'd936, 10'd1023,
    10'd12,
    10'd156, 10'd208, 10'd260, 10'd234, 10'd312, 10'd390,
    10'd208, 10'd260, 10'd260, 10'd312, 10'd364, 10'd364, 10'd416, 10'd312,
    10'd390, 10'd390, 10'd468, 10'd546, 10'd546, 10'd624,
    10'd260, 10'd312, 10'd364, 10'd312, 10'd364, 10'd416, 10'd468, 10'd416,
    10'd468, 10'd520, 10'd520, 10'd572,
    10'd390, 10'd468, 10'd546, 10'd468, 10'd546, 10'd624, 10'd702, 10'd624,
    10'd702, 10'd780, 10'd780, 10'd858
  };

  // Entry 31 is 1040, which needs eleven bits; the table stores 1023 there and this function returns 1040.
  function automatic logic [10:0] bits_per_sym(input logic [6:0] idx);
    logic [10:0] v;
    v = (idx == 7'd31) ? 11'd1040 : {1'b0, McsBitsPerSym[idx]};
    return v;
  endfunction

  localparam logic [2:0] DataLtfs [4] = '{3'd1, 3'd2, 3'd4, 3'd4};
  localparam logic [2:0] ExtLtfs  [4] = '{3'd0, 3'd1, 3'd2, 3'd4};

endpackage

[src/wifi_frame_airtime_core.sv]
// Top level of the frame air time core: decode, divider and back end.
//
// One frame description enters per beat on the slave stream; phy_kind travels
// in s_axis_tuser and the other fields in s_axis_tdata. One result leaves per
// input beat on the master stream: duration_us in m_axis_tdata, status in
// m_axis_tuser. Results keep input order.
// The pipeline has one decode stage, 21 divider stages (one quotient bit each),
// and three back-end stages (symbol scaling, multiply by the reciprocal of ten,
// output register). Throughput is one beat per cycle while the output is not stalled.
// The whole pipeline advances together; when the output register holds a beat
// the receiver has not taken, every stage holds and s_axis_tready is low, so
// nothing is lost or repeated. Bubbles travel as cleared valid bits.
// Reset clears all valid bits; no result is pending after reset.
`include "wifi_frame_airtime_core_defines.svh"
module wifi_frame_airtime_core
  import wfa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] byte length, [16] A-MPDU subframe, [17] first of burst, [25:18] rate_units,
  // [26] short DSSS preamble, [33:27] MCS, [34] bandwidth_40, [35] short guard,
  // [37:36] extra STBC streams, [40:38] extension_streams, [41] greenfield, rest zero
  input  logic [47:0] s_axis_tdata,
  // [2:0] phy_kind
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [20:0] duration_us, rest zero
  output logic [23:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]  m_axis_tuser
);

  logic            en;
  logic            f_valid, d_valid, b_valid;
  logic [NumW-1:0] f_num, d_quo;
  logic [DenW-1:0] f_den;
  side_t           f_side, d_side;
  logic [DurW-1:0] dur;
  logic [1:0]      status;

  // Global advance: move when the output register is empty or being taken.
  assign en            = !b_valid || m_axis_tready;
  assign s_axis_tready = en;

  wfa_front u_front (
    .clk_i,
    .rst_ni,
    .en_i                (en),
    .valid_i             (s_axis_tvalid),
    .phy_kind_i          (s_axis_tuser),
    .byte_len_i          (s_axis_tdata[15:0]),
    .ampdu_i             (s_axis_tdata[16]),
    .burst_first_i       (s_axis_tdata[17]),
    .rate_units_i        (s_axis_tdata[25:18]),
    .short_pre_i         (s_axis_tdata[26]),
    .mcs_i               (s_axis_tdata[33:27]),
    .bandwidth_40_i      (s_axis_tdata[34]),
    .sgi_i               (s_axis_tdata[35]),
    .stbc_extra_i        (s_axis_tdata[37:36]),
    .extension_streams_i (s_axis_tdata[40:38]),
    .greenfield_i        (s_axis_tdata[41]),
    .valid_o             (f_valid),
    .num_o               (f_num),
    .den_o               (f_den),
    .side_o              (f_side)
  );

  wfa_div u_div (
    .clk_i,
    .rst_ni,
    .en_i    (en),
    .valid_i (f_valid),
    .num_i   (f_num),
    .den_i   (f_den),
    .side_i  (f_side),
    .valid_o (d_valid),
    .quo_o   (d_quo),
    .side_o  (d_side)
  );

  wfa_back u_back (
    .clk_i,
    .rst_ni,
    .en_i     (en),
    .valid_i  (d_valid),
    .quo_i    (d_quo),
    .side_i   (d_side),
    .valid_o  (b_valid),
    .dur_o    (dur),
    .status_o (status)
  );

  assign m_axis_tvalid = b_valid;
  assign m_axis_tdata  = {3'b0, dur};
  assign m_axis_tuser  = status;

  // An errored beat never carries a duration.
  `WFA_ASSERT_NOW(a_err_zero_dur, m_axis_tvalid && m_axis_tuser != StOk, m_axis_tdata == 24'd0)
  // A held output beat stalls the input side.
  `WFA_ASSERT_NOW(a_stall_blocks_in, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  // A stalled divider output is still there next cycle.
  `WFA_ASSERT_NEXT(a_div_holds, d_valid && !en, d_valid && $stable(d_quo))

endmodule

[src/wfa_front.sv]
// Decode stage: mode, status, preamble, and the ceiling-division operands.
module wfa_front
  import wfa_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [2:0]      phy_kind_i,
  input  logic [15:0]     byte_len_i,
  input  logic            ampdu_i,
  input  logic            burst_first_i,
  input  logic [7:0]      rate_units_i,
  input  logic            short_pre_i,
  input  logic [6:0]      mcs_i,
  input  logic            bandwidth_40_i,
  input  logic            sgi_i,
  input  logic [1:0]      stbc_extra_i,
  input  logic [2:0]      extension_streams_i,
  input  logic            greenfield_i,
  output logic            valid_o,
  output logic [NumW-1:0] num_o,
  output logic [DenW-1:0] den_o,
  output side_t           side_o
);

  logic            valid_q;
  logic [NumW-1:0] num_q, num_d;
  logic [DenW-1:0] den_q, den_d;
  side_t           side_q, side_d;

  logic [7:0]      rate;
  logic [6:0]      idx;
  logic [2:0]      nsts;
  logic [1:0]      ltf_idx;
  logic [NumW-1:0] raw;
  logic [NumW-1:0] ht_bits;
  logic [DenW-1:0] ht_den;
  logic [7:0]      pre;

  // Operand selection per PHY; the ceiling comes from adding den - 1.
  always_comb begin
    rate    = (rate_units_i == 8'd0) ? 8'd2 : rate_units_i;
    idx     = (mcs_i > McsTop) ? 7'd0 : mcs_i;
    nsts    = McsStreams[idx] + {1'b0, stbc_extra_i};
    ltf_idx = 2'(nsts - 3'd1);
    ht_bits = {2'b0, byte_len_i, 3'b0};
    if (!ampdu_i) begin
      ht_bits = ht_bits + NumW'(16) + NumW'(6 * McsEncoders[idx]);
    end
    ht_den = DenW'(bits_per_sym(idx));
    if (bandwidth_40_i) ht_den = {ht_den[DenW-2:0], 1'b0};
    if (stbc_extra_i != 2'd0) ht_den = {ht_den[DenW-2:0], 1'b0};
    pre = (greenfield_i ? 8'd24 : 8'd32)
        + {3'b0, DataLtfs[ltf_idx], 2'b0} + {3'b0, ExtLtfs[extension_streams_i[1:0]], 2'b0};

    raw          = '0;
    den_d        = DenW'(1);
    side_d.mode  = MODE_ERR;
    side_d.status = StUnsupp;
    side_d.base  = 8'd0;
    side_d.stbc2 = (stbc_extra_i != 2'd0);
    side_d.sgi   = sgi_i;
    unique case (phy_kind_i)
      PhyDsss: begin
        raw           = {1'b0, byte_len_i, 4'b0};
        den_d         = DenW'(rate);
        side_d.mode   = MODE_DSSS;
        side_d.status = StOk;
        side_d.base   = short_pre_i ? 8'd96 : 8'd192;
      end
      PhyOfdm: begin
        raw           = {2'b0, byte_len_i, 3'b0} + NumW'(22);
        den_d         = DenW'({rate, 1'b0});
        side_d.mode   = MODE_OFDM;
        side_d.status = StOk;
      end
      PhyHt: begin
        if (burst_first_i && extension_streams_i > 3'd3) begin
          side_d.status = StStreams;
        end else if (mcs_i > McsTop) begin
          side_d.status = StMcs;
        end else if (burst_first_i && nsts > 3'd4) begin
          side_d.status = StStreams;
        end else begin
          raw           = ht_bits;
          den_d         = ht_den;
          side_d.mode   = MODE_HT;
          side_d.status = StOk;
          side_d.base   = burst_first_i ? pre : 8'd0;
        end
      end
      default: begin
        side_d.status = StUnsupp;
      end
    endcase
    num_d = raw + NumW'(den_d) - NumW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= num_d;
      den_q  <= den_d;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign side_o  = side_q;

endmodule

[src/wfa_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module wfa_div
  import wfa_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  input  side_t           side_i,
  output logic            valid_o,
  output logic [NumW-1:0] quo_o,
  output side_t           side_o
);

  logic            valid_q [NumW];
  logic [DenW-1:0] rem_q   [NumW];
  logic [NumW-1:0] nq_q    [NumW];
  logic [DenW-1:0] den_q   [NumW];
  side_t           side_q  [NumW];

  logic [DenW-1:0] rem_d [NumW];
  logic [NumW-1:0] nq_d  [NumW];

  // Each stage shifts one numerator bit into the remainder and one quotient bit into the low end.
  always_comb begin
    for (int i = 0; i < NumW; i++) begin
      logic [DenW-1:0] rem_in;
      logic [NumW-1:0] nq_in;
      logic [DenW-1:0] dv;
      logic [DenW:0]   trial;
      rem_in = (i == 0) ? '0 : rem_q[(i == 0) ? 0 : i - 1];
      nq_in  = (i == 0) ? num_i : nq_q[(i == 0) ? 0 : i - 1];
      dv     = (i == 0) ? den_i : den_q[(i == 0) ? 0 : i - 1];
      trial  = {rem_in, nq_in[NumW-1]};
      if (trial >= {1'b0, dv}) begin
        rem_d[i] = DenW'(trial - {1'b0, dv});
        nq_d[i]  = {nq_in[NumW-2:0], 1'b1};
      end else begin
        rem_d[i] = DenW'(trial);
        nq_d[i]  = {nq_in[NumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumW; i++) valid_q[i] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
      for (int i = 1; i < NumW; i++) valid_q[i] <= valid_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
      for (int i = 1; i < NumW; i++) begin
        den_q[i]  <= den_q[i-1];
        side_q[i] <= side_q[i-1];
      end
      for (int i = 0; i < NumW; i++) begin
        rem_q[i] <= rem_d[i];
        nq_q[i]  <= nq_d[i];
      end
    end
  end

  assign valid_o = valid_q[NumW-1];
  assign quo_o   = nq_q[NumW-1];
  assign side_o  = side_q[NumW-1];

endmodule

[src/wfa_back.sv]
// Back end: symbol time scaling, divide by ten, final sum and output register.
module wfa_back
  import wfa_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [NumW-1:0] quo_i,
  input  side_t           side_i,
  output logic            valid_o,
  output logic [DurW-1:0] dur_o,
  output logic [1:0]      status_o
);

  localparam logic [31:0] Recip10 = 32'hCCCCCCCD;

  logic            v1_q, v2_q, v3_q;
  logic            ht1_q, ht2_q;
  logic [1:0]      st1_q, st2_q, st3_q;
  logic [7:0]      base1_q, base2_q;
  logic [21:0]     x_q, x_d;
  logic [DurW-1:0] leg1_q, leg2_q, leg_d;
  logic [53:0]     prod_q;
  logic [DurW-1:0] dur_q, dur_d;
  logic [17:0]     syms;

  // Stage one: whole symbols in tenths of a microsecond, or the legacy sum.
  always_comb begin
    syms = side_i.stbc2 ? {quo_i[16:0], 1'b0} : {1'b0, quo_i[16:0]};
    x_d  = ({4'b0, syms} * (side_i.sgi ? 22'd36 : 22'd40)) + 22'd5;
    if (side_i.mode == MODE_DSSS) begin
      leg_d = quo_i + DurW'(side_i.base);
    end else begin
      leg_d = {quo_i[DurW-3:0], 2'b0} + DurW'(20);
    end
  end

  // Stage three: rounded microseconds plus preamble, or the legacy sum; zero on any error.
  always_comb begin
    if (st2_q != StOk) begin
      dur_d = '0;
    end else if (ht2_q) begin
      dur_d = DurW'(prod_q[53:35]) + DurW'(base2_q);
    end else begin
      dur_d = leg2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ht1_q   <= (side_i.mode == MODE_HT);
      st1_q   <= side_i.status;
      base1_q <= side_i.base;
      x_q     <= x_d;
      leg1_q  <= leg_d;
      ht2_q   <= ht1_q;
      st2_q   <= st1_q;
      base2_q <= base1_q;
      leg2_q  <= leg1_q;
      prod_q  <= x_q * Recip10;
      st3_q   <= st2_q;
      dur_q   <= dur_d;
    end
  end

  assign valid_o  = v3_q;
  assign dur_o    = dur_q;
  assign status_o = st3_q;

endmodule
